>>> hdl/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int TICK_W        = 32;
  localparam int SLOT_OUT_W    = 4;
  localparam int CNT_W         = 5;
  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [CNT_W-1:0] COUNT_RST = 5'd1;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_DEAD     = 3'd4
  } slot_st_t;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_YIELD  = 2'd1,
    OP_EXIT   = 2'd2,
    OP_SLEEP  = 2'd3
  } op_t;

  typedef struct packed {
    logic accept;
    logic op_wr;
    logic rd_en;
    logic sw_dec;
    logic sw_apply;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_create;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> hdl/round_robin_task_scheduler_top.sv
`default_nettype none

// Round-robin task scheduler. Each accepted event (create, yield, exit, sleep)
// returns exactly one result. The block works on one event at a time: each event
// is handled by a single pass over the slot table, one slot per cycle through one
// read port. For create the pass finds the first unused slot; for the others it
// wakes due sleepers and finds the next ready slot. A finished result waits in
// the output register, so the next event is taken while it is still stalled. No
// clearing pass is needed after reset; untouched slots read as their reset state.
module round_robin_task_scheduler_top #(
  parameter int NUM_SLOTS = rrts_pkg::NUM_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_operation,
  input  logic [rrts_pkg::TICK_W-1:0]     in_now,
  input  logic [rrts_pkg::TICK_W-1:0]     in_sleep_ticks,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rrts_pkg::SLOT_OUT_W-1:0] out_created_slot,
  output logic                            out_create_ok,
  output logic [rrts_pkg::SLOT_OUT_W-1:0] out_running_task,
  output logic [rrts_pkg::SLOT_OUT_W-1:0] out_previous_task,
  output logic                            out_switched,
  output logic [rrts_pkg::CNT_W-1:0]      out_active_count
);
  import rrts_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrts_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_operation),
    .in_now            (in_now),
    .in_sleep_ticks    (in_sleep_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_created_slot  (out_created_slot),
    .out_create_ok     (out_create_ok),
    .out_running_task  (out_running_task),
    .out_previous_task (out_previous_task),
    .out_switched      (out_switched),
    .out_active_count  (out_active_count)
  );

endmodule

`default_nettype wire

>>> hdl/rrts_ctrl.sv
`default_nettype none

module rrts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rrts_pkg::dp_sts_t sts,
  output rrts_pkg::dp_cmd_t cmd
);
  import rrts_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_OPW   = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_SWA   = 7'b0010000,
    S_SWB   = 7'b0100000,
    S_FIN   = 7'b1000000
  } fsm_t;

  fsm_t state_r;
  fsm_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_OPW;
        end
      end
      S_OPW: begin
        cmd.op_wr = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = sts.is_create ? S_FIN : S_SWA;
      end
      S_SWA: begin
        cmd.sw_dec = 1'b1;
        state_nxt  = S_SWB;
      end
      S_SWB: begin
        cmd.sw_apply = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rrts_dp.sv
`default_nettype none

module rrts_dp #(
  parameter int NUM_SLOTS = rrts_pkg::NUM_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rrts_pkg::dp_cmd_t                   cmd,
  output rrts_pkg::dp_sts_t                   sts,
  input  logic [1:0]                          in_operation,
  input  logic [rrts_pkg::TICK_W-1:0]         in_now,
  input  logic [rrts_pkg::TICK_W-1:0]         in_sleep_ticks,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rrts_pkg::SLOT_OUT_W-1:0]     out_created_slot,
  output logic                                out_create_ok,
  output logic [rrts_pkg::SLOT_OUT_W-1:0]     out_running_task,
  output logic [rrts_pkg::SLOT_OUT_W-1:0]     out_previous_task,
  output logic                                out_switched,
  output logic [rrts_pkg::CNT_W-1:0]          out_active_count
);
  import rrts_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

  slot_st_t          state_mem [NUM_SLOTS];
  logic [TICK_W-1:0] wake_mem  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_r;

  op_t               op_r;
  logic [TICK_W-1:0] now_r;
  logic [TICK_W-1:0] tk_r;
  logic [SW-1:0]     cur_r;
  logic [SW-1:0]     prev_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SW-1:0]     addr_r;
  logic [SW-1:0]     visit_r;
  logic              rd_pend_r;
  logic [SW-1:0]     rd_addr_r;
  logic              rd_vld_r;
  slot_st_t          st_rd_r;
  logic [TICK_W-1:0] wk_rd_r;
  logic              found_r;
  logic [SW-1:0]     pick_r;
  logic              sw_r;
  logic              out_valid_r;

  logic              st_we;
  logic              wk_we;
  logic [SW-1:0]     wa;
  slot_st_t          wd;
  logic [TICK_W-1:0] wkd;
  slot_st_t          eff;
  logic              due;
  logic              hit;
  logic              is_create;
  logic              cur_run;
  logic [SW-1:0]     next_slot;
  logic              no_switch;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    slot_inc = (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  assign is_create = (op_r == OP_CREATE);
  assign cur_run   = (op_r == OP_YIELD);
  assign eff       = rd_vld_r ? st_rd_r : ((rd_addr_r == '0) ? ST_RUNNING : ST_UNUSED);
  assign due       = (eff == ST_SLEEPING) && (now_r >= wk_rd_r);
  assign hit       = is_create ? (eff == ST_UNUSED) : ((eff == ST_READY) || due);
  assign next_slot = found_r ? pick_r : (cur_run ? cur_r : '0);
  assign no_switch = (next_slot == cur_r) && cur_run;

  assign sts.is_create = is_create;
  assign sts.scan_last = (visit_r == LAST_SLOT);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    st_we = 1'b0;
    wk_we = 1'b0;
    wa    = cur_r;
    wd    = ST_READY;
    wkd   = now_r + tk_r;
    if (cmd.op_wr) begin
      if (op_r == OP_EXIT) begin
        st_we = 1'b1;
        wd    = ST_DEAD;
      end else if (op_r == OP_SLEEP) begin
        st_we = 1'b1;
        wk_we = 1'b1;
        wd    = ST_SLEEPING;
      end
    end else if (rd_pend_r) begin
      wa = rd_addr_r;
      if (is_create) begin
        st_we = !found_r && hit;
      end else begin
        st_we = due;
      end
    end else if (cmd.sw_dec) begin
      st_we = !no_switch && cur_run;
    end else if (cmd.sw_apply) begin
      st_we = sw_r;
      wa    = next_slot;
      wd    = ST_RUNNING;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      state_mem[wa] <= wd;
    end
    if (wk_we) begin
      wake_mem[wa] <= wkd;
    end
    st_rd_r   <= state_mem[addr_r];
    wk_rd_r   <= wake_mem[addr_r];
    rd_vld_r  <= vld_r[addr_r];
    rd_addr_r <= addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (st_we) begin
      vld_r[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= op_t'(in_operation);
      now_r  <= in_now;
      tk_r   <= in_sleep_ticks;
      prev_r <= cur_r;
      addr_r <= (op_t'(in_operation) == OP_CREATE) ? '0 : slot_inc(cur_r);
    end else if (cmd.rd_en) begin
      addr_r <= slot_inc(addr_r);
    end
    if (rd_pend_r && !found_r && hit) begin
      pick_r <= rd_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      cnt_r       <= COUNT_RST;
      visit_r     <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      sw_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_en;
      if (cmd.accept) begin
        visit_r <= '0;
        found_r <= 1'b0;
        sw_r    <= 1'b0;
      end else if (cmd.rd_en) begin
        visit_r <= visit_r + 1'b1;
      end
      if (rd_pend_r && hit) begin
        found_r <= 1'b1;
      end
      if (cmd.op_wr && (op_r == OP_EXIT) && (cnt_r != '0)) begin
        cnt_r <= cnt_r - 1'b1;
      end else if (rd_pend_r && is_create && !found_r && hit && (cnt_r != COUNT_MAX)) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.sw_dec) begin
        sw_r <= !no_switch;
      end
      if (cmd.sw_apply && sw_r) begin
        cur_r <= next_slot;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_created_slot  <= (is_create && found_r) ? SLOT_OUT_W'(pick_r) : '0;
      out_create_ok     <= is_create && found_r;
      out_running_task  <= SLOT_OUT_W'(cur_r);
      out_previous_task <= SLOT_OUT_W'(prev_r);
      out_switched      <= sw_r;
      out_active_count  <= cnt_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> hdl/rrts_chk.sv
`default_nettype none

module rrts_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_created_slot,
  input logic       out_create_ok,
  input logic [3:0] out_running_task,
  input logic [3:0] out_previous_task,
  input logic       out_switched,
  input logic [4:0] out_active_count
);

  a_no_slot_without_create: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_create_ok |-> out_created_slot == 4'd0)
    else $error("created slot set without a successful create");

  a_create_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_create_ok |-> !out_switched)
    else $error("create reported a switch");

  a_stay_same_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_switched |-> out_running_task == out_previous_task)
    else $error("running task changed without a switch");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_running_task)
      && $stable(out_active_count) && $stable(out_switched))
    else $error("stalled transfer changed");

endmodule

bind round_robin_task_scheduler_top rrts_chk u_rrts_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_created_slot  (out_created_slot),
  .out_create_ok     (out_create_ok),
  .out_running_task  (out_running_task),
  .out_previous_task (out_previous_task),
  .out_switched      (out_switched),
  .out_active_count  (out_active_count)
);

`default_nettype wire

>>> tb/round_robin_task_scheduler_top_tb.sv
`timescale 1ns / 1ps

module round_robin_task_scheduler_top_tb;

  import rrts_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam int DRAIN_CYCLES = 60;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [SLOT_OUT_W-1:0] slot_id_t;

  typedef struct {
    slot_id_t         created_slot;
    logic             create_ok;
    slot_id_t         running_task;
    slot_id_t         previous_task;
    logic             switched;
    logic [CNT_W-1:0] active_count;
  } decision_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_operation;
  tick_t      in_now;
  tick_t      in_sleep_ticks;
  logic       out_valid;
  logic       out_stall;
  slot_id_t   out_created_slot;
  logic       out_create_ok;
  slot_id_t   out_running_task;
  slot_id_t   out_previous_task;
  logic       out_switched;
  logic [CNT_W-1:0] out_active_count;

  slot_st_t         task_state [SLOTS];
  tick_t            wake_at [SLOTS];
  int               cur_slot;
  logic [CNT_W-1:0] live_tasks;

  decision_t decision_q [$];
  decision_t want;
  int        mismatches;
  int        checked_count;
  int        op_hits [4];
  int        burst_left;
  tick_t     tick_now;

  round_robin_task_scheduler_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_now            (in_now),
    .in_sleep_ticks    (in_sleep_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_created_slot  (out_created_slot),
    .out_create_ok     (out_create_ok),
    .out_running_task  (out_running_task),
    .out_previous_task (out_previous_task),
    .out_switched      (out_switched),
    .out_active_count  (out_active_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic reset_scheduler_state();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      task_state[i] = ST_UNUSED;
      wake_at[i]    = '0;
    end
    task_state[0] = ST_RUNNING;
    cur_slot      = 0;
    live_tasks    = COUNT_RST;
  endtask

  task automatic advance_scheduler(input op_t op, input tick_t now, input tick_t ticks);
    decision_t d;
    int        i;
    int        idx;
    int        next;
    bit        found;
    d.created_slot  = '0;
    d.create_ok     = 1'b0;
    d.switched      = 1'b0;
    d.previous_task = slot_id_t'(cur_slot);
    if (op == OP_CREATE) begin
      found = 1'b0;
      for (i = 0; i < SLOTS && !found; i++) begin
        if (task_state[i] == ST_UNUSED) begin
          task_state[i] = ST_READY;
          wake_at[i]    = '0;
          if (live_tasks < COUNT_MAX) live_tasks++;
          d.created_slot = slot_id_t'(i);
          d.create_ok    = 1'b1;
          found          = 1'b1;
        end
      end
    end else begin
      if (op == OP_EXIT) begin
        task_state[cur_slot] = ST_DEAD;
        if (live_tasks > 0) live_tasks--;
      end else if (op == OP_SLEEP) begin
        task_state[cur_slot] = ST_SLEEPING;
        wake_at[cur_slot]    = now + ticks;
      end
      for (i = 0; i < SLOTS; i++) begin
        if (task_state[i] == ST_SLEEPING && now >= wake_at[i]) task_state[i] = ST_READY;
      end
      found = 1'b0;
      next  = 0;
      for (i = 1; i <= SLOTS && !found; i++) begin
        idx = (cur_slot + i) % SLOTS;
        if (task_state[idx] == ST_READY) begin
          next  = idx;
          found = 1'b1;
        end
      end
      if (!found) next = (task_state[cur_slot] == ST_RUNNING) ? cur_slot : 0;
      if (!(next == cur_slot && task_state[cur_slot] == ST_RUNNING)) begin
        if (task_state[cur_slot] == ST_RUNNING) task_state[cur_slot] = ST_READY;
        cur_slot         = next;
        task_state[next] = ST_RUNNING;
        d.switched       = 1'b1;
      end
    end
    d.running_task = slot_id_t'(cur_slot);
    d.active_count = live_tasks;
    decision_q.push_back(d);
  endtask

  task automatic send_event(input op_t op, input tick_t now, input tick_t ticks);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_now         <= now;
    in_sleep_ticks <= ticks;
    do @(posedge clk); while (in_stall);
    advance_scheduler(op, now, ticks);
    op_hits[op]++;
  endtask

  function automatic void check_field(input string field, input logic [31:0] exp_val,
                                      input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, field, exp_val, got_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decision_q.size() == 0) begin
        $display("%0t ns: result transfer with nothing expected: running %0d previous %0d",
                 $time, out_running_task, out_previous_task);
        mismatches++;
      end else begin
        want = decision_q.pop_front();
        check_field("created_slot", want.created_slot, out_created_slot);
        check_field("create_ok", want.create_ok, out_create_ok);
        check_field("running_task", want.running_task, out_running_task);
        check_field("previous_task", want.previous_task, out_previous_task);
        check_field("switched", want.switched, out_switched);
        check_field("active_count", want.active_count, out_active_count);
        checked_count++;
      end
    end
  end

  initial begin
    stall_mode_t mode;
    int          len;
    int          phase;
    out_stall = 1'b0;
    phase     = 0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      len  = $urandom_range(20, 200);
      repeat (len) begin
        @(negedge clk);
        phase++;
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          STALL_PERIODIC: out_stall <= phase[2];
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  // lone task in slot 0: exit saturation, sleep waking at once, fallback to slot 0
  task automatic test_lone_task();
    send_event(OP_EXIT, 32'd0, 32'd0);
    send_event(OP_EXIT, 32'd0, 32'hFFFF_FFFF);
    send_event(OP_SLEEP, 32'd100, 32'd0);
    send_event(OP_SLEEP, 32'd0, 32'hFFFF_FFFF);
    send_event(OP_YIELD, 32'd0, 32'd0);
    send_event(OP_SLEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // dead slot must be skipped by the following create
  task automatic test_create_and_reuse();
    repeat (3) send_event(OP_CREATE, 32'd10, 32'd0);
    send_event(OP_YIELD, 32'd20, 32'd0);
    send_event(OP_EXIT, 32'd30, 32'd0);
    send_event(OP_CREATE, 32'd40, 32'hFFFF_FFFF);
  endtask

  task automatic test_sleep_wake();
    send_event(OP_SLEEP, 32'd1000, 32'd50);
    send_event(OP_YIELD, 32'd1040, 32'd0);
    send_event(OP_YIELD, 32'd1050, 32'd0);
  endtask

  task automatic test_full_table();
    repeat (SLOTS - 4) send_event(OP_CREATE, 32'd2000, 32'd0);
  endtask

  task automatic test_random_events(input int count);
    int    pick;
    op_t   op;
    tick_t ticks;
    tick_now = 32'd5000;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) op = OP_CREATE;
      else if (pick < 11) op = OP_EXIT;
      else if (pick < 50) op = OP_YIELD;
      else op = OP_SLEEP;
      pick = $urandom_range(0, 99);
      if (pick < 4) tick_now = $urandom();
      else if (pick < 6) tick_now = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else tick_now = tick_now + $urandom_range(0, 24);
      pick = $urandom_range(0, 9);
      if (op != OP_SLEEP || pick == 6 || pick == 7) ticks = $urandom();
      else if (pick == 8) ticks = 32'hFFFF_FFFF - $urandom_range(0, 60);
      else if (pick == 9) ticks = '0;
      else ticks = $urandom_range(0, 60);
      send_event(op, tick_now, ticks);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_YIELD;
    in_now         = '0;
    in_sleep_ticks = '0;
    mismatches     = 0;
    checked_count  = 0;
    burst_left     = 0;
    op_hits        = '{default: 0};
    reset_scheduler_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_lone_task();
    test_create_and_reuse();
    test_sleep_wake();
    test_full_table();
    test_random_events(450);

    @(negedge clk);
    in_valid <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Scheduler events sent: %0d create, %0d yield, %0d exit, %0d sleep",
             op_hits[OP_CREATE], op_hits[OP_YIELD], op_hits[OP_EXIT], op_hits[OP_SLEEP]);
    $display("Results compared: %0d, mismatches: %0d", checked_count, mismatches);
    if (mismatches == 0 && decision_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
hdl/rrts_pkg.sv
hdl/rrts_ctrl.sv
hdl/rrts_dp.sv
hdl/round_robin_task_scheduler_top.sv
hdl/rrts_chk.sv
tb/round_robin_task_scheduler_top_tb.sv
